@@ design/swm_pkg.sv @@
// Shared types and constants for the sliding window median filter.
package swm_pkg;

   // Field widths fixed by the interface
   localparam int SAMPLE_W = 32;
   localparam int CFG_W    = 6;

   // Default depth of the cell row and reset value of the window register
   localparam int               MAX_WINDOW_DEF = 32;
   localparam logic [CFG_W-1:0] WINDOW_RESET   = 6'd3;

   // Per-cell status handed to both neighbors
   typedef struct packed {
      logic surv;   // cell holds a live entry that stays in the window
      logic le;     // live entry orders at or below the incoming sample
      logic d_pre;  // the evicted entry sits in some cell before this one
      logic del;    // this cell holds the entry being evicted
   } cell_flags_type;

endpackage

@@ design/sliding_window_median.sv @@
// Top level of the sliding window median filter: cell row, fill control and result register.
//
// Takes one signed sample per clock into a row of MAX_WINDOW cells that keep the window
// sorted; each cell tracks the age of its sample, so eviction of the oldest and insertion of
// the new one happen together on the accepting edge. Once the window holds window_size samples,
// each beat produces the lower median on rsp_: the row updates at the accepting edge, and the
// median select loads the output register once that register is free. Sustained rate is
// one sample per clock; req_ready drops only while a result
// waits for its turn behind a stalled output register. Writing window_size (0 acts as 1,
// values above MAX_WINDOW saturate) restarts the sequence. No clearing pass is needed
// after reset.
module sliding_window_median import swm_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_median,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CFG_W-1:0]           csr_window_size
);

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   logic [CFG_W-1:0]           win_ff;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic                       pend_ff, pend_in;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_median_ff;
   logic [AGE_W-1:0]           mid_ff;
   logic [CNT_W-1:0]           w_eff;
   logic [CNT_W-1:0]           wlast;
   logic                       accept;
   logic                       move_ok;
   logic                       emit;

   logic signed [SAMPLE_W-1:0] cell_value [MAX_WINDOW];
   logic [AGE_W-1:0]           cell_age   [MAX_WINDOW];
   cell_flags_type             cell_flags [MAX_WINDOW];

   // Effective window length
   always_comb begin
      if (win_ff == '0) begin
         w_eff = CNT_W'(1);
      end else if (32'(win_ff) > 32'(MAX_WINDOW)) begin
         w_eff = CNT_W'(MAX_WINDOW);
      end else begin
         w_eff = CNT_W'(win_ff);
      end
      wlast = w_eff - 1'b1;
   end

   // Handshakes
   assign move_ok   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !pend_ff || move_ok;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign emit      = ({1'b0, fill_ff} + 1'b1) >= {1'b0, w_eff};

   // Fill count and pending result
   always_comb begin
      fill_in = fill_ff;
      if (accept && (fill_ff < w_eff)) begin
         fill_in = fill_ff + 1'b1;
      end
      if (accept) begin
         pend_in = emit;
      end else if (move_ok) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= WINDOW_RESET;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            win_ff  <= csr_window_size;
            fill_ff <= '0;
         end else begin
            fill_ff <= fill_in;
         end
         pend_ff <= pend_in;
         if (pend_ff && move_ok) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Median index and result register
   always_ff @(posedge clock) begin
      mid_ff <= AGE_W'(wlast >> 1);
      if (pend_ff && move_ok) begin
         rsp_median_ff <= cell_value[mid_ff];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

   // Row of sorted cells
   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic signed [SAMPLE_W-1:0] lv, rv;
      logic [AGE_W-1:0]           la, ra;
      cell_flags_type             lf, rf;

      if (i == 0) begin : g_first
         assign lv = '0;
         assign la = '0;
         assign lf = '0;
      end else begin : g_mid_l
         assign lv = cell_value[i-1];
         assign la = cell_age[i-1];
         assign lf = cell_flags[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_last
         assign rv = '0;
         assign ra = '0;
         assign rf = '0;
      end else begin : g_mid_r
         assign rv = cell_value[i+1];
         assign ra = cell_age[i+1];
         assign rf = cell_flags[i+1];
      end

      swm_cell #(
         .MAX_WINDOW (MAX_WINDOW),
         .IDX        (i),
         .CNT_W      (CNT_W),
         .AGE_W      (AGE_W)
      ) u_cell (
         .clock          (clock),
         .go             (accept),
         .sample_in      (req_sample),
         .fill_in        (fill_ff),
         .wlast_in       (wlast),
         .left_value_in  (lv),
         .left_age_in    (la),
         .left_flags_in  (lf),
         .right_value_in (rv),
         .right_age_in   (ra),
         .right_flags_in (rf),
         .value_out      (cell_value[i]),
         .age_out        (cell_age[i]),
         .flags_out      (cell_flags[i])
      );
   end

endmodule

@@ design/swm_cell.sv @@
// One cell of the sorted row: holds a sample and its age, moves by at most one place on each beat.
module swm_cell import swm_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF,
   parameter int IDX        = 0,
   parameter int CNT_W      = $clog2(MAX_WINDOW + 1),
   parameter int AGE_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
   input  logic                       clock,
   input  logic                       go,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   input  logic [CNT_W-1:0]           fill_in,
   input  logic [CNT_W-1:0]           wlast_in,
   input  logic signed [SAMPLE_W-1:0] left_value_in,
   input  logic [AGE_W-1:0]           left_age_in,
   input  cell_flags_type             left_flags_in,
   input  logic signed [SAMPLE_W-1:0] right_value_in,
   input  logic [AGE_W-1:0]           right_age_in,
   input  cell_flags_type             right_flags_in,
   output logic signed [SAMPLE_W-1:0] value_out,
   output logic [AGE_W-1:0]           age_out,
   output cell_flags_type             flags_out
);

   logic signed [SAMPLE_W-1:0] value_ff, value_in;
   logic [AGE_W-1:0]           age_ff, age_in;
   logic                       valid;
   logic                       del;
   logic                       d_pre;
   logic                       le;
   logic                       from_left, from_right, stay;

   // Status of this cell against the incoming sample
   always_comb begin
      valid = (CNT_W'(IDX) < fill_in);
      del   = valid && (CNT_W'(age_ff) == wlast_in);
      d_pre = left_flags_in.d_pre | left_flags_in.del;
      le    = valid && !del && (value_ff <= sample_in);
      flags_out.surv  = valid && !del;
      flags_out.le    = le;
      flags_out.d_pre = d_pre;
      flags_out.del   = del;
   end

   // Survivor moves right if above sample and before eviction, left if not above and after it
   always_comb begin
      from_left  = left_flags_in.surv && !left_flags_in.le && !left_flags_in.d_pre;
      from_right = right_flags_in.surv && right_flags_in.le && right_flags_in.d_pre;
      stay       = valid && !del && (le ^ d_pre);
      if (from_left) begin
         value_in = left_value_in;
         age_in   = left_age_in + 1'b1;
      end else if (from_right) begin
         value_in = right_value_in;
         age_in   = right_age_in + 1'b1;
      end else if (stay) begin
         value_in = value_ff;
         age_in   = age_ff + 1'b1;
      end else begin
         value_in = sample_in;
         age_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   assign value_out = value_ff;
   assign age_out   = age_ff;

endmodule

@@ sim/testbench.sv @@
// Testbench for the sliding window median filter: directed and random streams vs. a predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import swm_pkg::*;

   localparam int DEPTH      = MAX_WINDOW_DEF;
   localparam int SETTLE     = 6;     // covers the two-register sample-to-median path
   localparam int IDLE_LIMIT = 1000;  // cycles with no handshake on any channel
   localparam int LONG_HOLD  = 80;    // output stall long enough to back up the input
   localparam int REPORT_MAX = 10;
   localparam int RANDOM_TARGET = 1450;

   typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_EDGES, SPREAD_MIXED} spread_type;

   // Clock, reset and block inputs, all known from time zero
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_ready = 1'b0;
   logic                       csr_valid = 1'b0;
   logic [CFG_W-1:0]           csr_window_size = '0;
   logic                       req_ready;
   logic                       rsp_valid;
   logic signed [SAMPLE_W-1:0] rsp_median;
   logic                       csr_ready;

   // Predictor state: window register, ring in arrival order, ascending copy
   logic [CFG_W-1:0]           win_setting = WINDOW_RESET;
   logic signed [SAMPLE_W-1:0] arrival_ring [DEPTH];
   logic signed [SAMPLE_W-1:0] ranked [DEPTH];
   int unsigned                held = 0;
   int unsigned                ring_head = 0;

   logic signed [SAMPLE_W-1:0] pending_medians [$];

   bit idle_en = 1'b1;
   int hold_request = 0;
   int hold_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;
   int samples_sent = 0;
   int medians_checked = 0;
   int windows_written = 0;

   sliding_window_median #(
      .MAX_WINDOW (DEPTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_median      (rsp_median),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_window_size (csr_window_size)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Effective window: zero acts as one, large values saturate
   function automatic int unsigned window_len();
      int unsigned w;
      w = 32'(win_setting);
      if (w == 0) w = 1;
      if (w > DEPTH) w = DEPTH;
      return w;
   endfunction

   // Place v after every entry that orders at or below it
   function automatic void rank_insert(logic signed [SAMPLE_W-1:0] v, int unsigned n);
      int unsigned pos;
      pos = 0;
      while (pos < n && ranked[pos] <= v) pos++;
      for (int unsigned i = n; i > pos; i--) ranked[i] = ranked[i-1];
      ranked[pos] = v;
   endfunction

   // Drop a single copy of v, duplicates stay
   function automatic void rank_remove(logic signed [SAMPLE_W-1:0] v, int unsigned n);
      int unsigned pos;
      pos = 0;
      while (pos < n && ranked[pos] != v) pos++;
      if (pos < n) begin
         for (int unsigned i = pos; i + 1 < n; i++) ranked[i] = ranked[i+1];
      end
   endfunction

   // One sample in; returns 1 with the lower median once the window is full
   function automatic bit advance_window(input logic signed [SAMPLE_W-1:0] s,
                                         output logic signed [SAMPLE_W-1:0] med);
      int unsigned w;
      int unsigned slot;
      w = window_len();
      if (held < w) begin
         rank_insert(s, held);
         arrival_ring[held] = s;
         held++;
         ring_head = 0;
         if (held < w) return 1'b0;
      end else begin
         slot = ring_head;
         if (slot >= w) slot = 0;
         rank_remove(arrival_ring[slot], w);
         rank_insert(s, w - 1);
         arrival_ring[slot] = s;
         slot++;
         if (slot >= w) slot = 0;
         ring_head = slot;
      end
      med = ranked[(w + 1) / 2 - 1];
      return 1'b1;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(spread_type how);
      if (how == SPREAD_MIXED) how = spread_type'($urandom_range(SPREAD_FULL, SPREAD_EDGES));
      case (how)
         SPREAD_NARROW: return $signed($urandom_range(0, 8)) - 4;
         SPREAD_EDGES: begin
            case ($urandom_range(0, 3))
               0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
               1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
               2:       return '0;
               default: return '1;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   // Offer one sample, with an optional random gap first
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      logic signed [SAMPLE_W-1:0] med;
      if (idle_en && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      samples_sent++;
      if (advance_window(s, med)) pending_medians = {pending_medians, med};
   endtask

   // Stop offering, wait for every pending median, then let the row settle
   task automatic pause_sender();
      req_valid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Window write only with the block idle; it also restarts the sequence
   task automatic write_window(input logic [CFG_W-1:0] w);
      pause_sender();
      csr_valid       <= 1'b1;
      csr_window_size <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      win_setting = w;
      held = 0;
      ring_head = 0;
      windows_written++;
   endtask

   task automatic log_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("%0t: mismatch: %s", $time, what);
   endtask

   // Reset window of 3: field extremes and equal samples
   task automatic test_default_window();
      logic signed [SAMPLE_W-1:0] seq [9] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1,
                                               5, 5, 5, -5};
      foreach (seq[i]) send_sample(seq[i]);
   endtask

   // Window register of zero behaves as pass-through
   task automatic test_zero_window();
      write_window('0);
      send_sample(32'sh7FFF_FFFF);
      send_sample(32'sh8000_0000);
      send_sample(-1);
      send_sample(12345);
   endtask

   task automatic test_unit_window();
      write_window(6'd1);
      send_sample(-7);
      send_sample(0);
      send_sample(32'sh8000_0000);
      send_sample(32'sh7FFF_FFFF);
   endtask

   // Window of two: duplicates must leave one copy behind on eviction
   task automatic test_equal_samples();
      write_window(6'd2);
      send_sample(7);
      send_sample(7);
      send_sample(7);
      send_sample(-7);
      send_sample(-7);
      send_sample(7);
   endtask

   // Random phases over many window settings, with and without idling
   task automatic test_random_windows();
      int sent;
      int phase;
      int count;
      logic [CFG_W-1:0] w;
      spread_type how;
      sent = 0;
      phase = 0;
      while (sent < RANDOM_TARGET) begin
         case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = 6'd1;
            2:       w = 6'd32;
            3:       w = CFG_W'($urandom_range(33, 63));
            4:       w = '1;
            5, 6:    w = CFG_W'($urandom_range(9, 31));
            default: w = CFG_W'($urandom_range(2, 8));
         endcase
         if (phase == 0) w = 6'd32;
         if (phase == 1) w = '1;
         idle_en = ($urandom_range(0, 3) != 0);
         write_window(w);
         how = spread_type'($urandom_range(SPREAD_FULL, SPREAD_MIXED));
         count = window_len() + $urandom_range(0, 40);
         repeat (count) send_sample(pick_sample(how));
         sent += count;
         phase++;
      end
      idle_en = 1'b1;
   endtask

   // Long output stall while the sender keeps offering
   task automatic test_output_stall();
      write_window(6'd5);
      hold_request = LONG_HOLD;
      repeat (40) send_sample(pick_sample(SPREAD_FULL));
   endtask

   // Sender waits for all medians mid-sequence, then the same stream resumes
   task automatic test_sender_pause();
      write_window(CFG_W'($urandom_range(3, 8)));
      repeat (20) send_sample(pick_sample(SPREAD_MIXED));
      pause_sender();
      repeat (20) send_sample(pick_sample(SPREAD_MIXED));
   endtask

   // Last part: no idling on either side
   task automatic test_full_rate();
      idle_en = 1'b0;
      write_window(CFG_W'($urandom_range(2, 9)));
      repeat (250) send_sample(pick_sample(SPREAD_MIXED));
   endtask

   // Result side: random stalls, plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request != 0) begin
         hold_left = hold_request - 1;
         hold_request = 0;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each result beat with the oldest expected median
   always @(posedge clock) begin
      logic signed [SAMPLE_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_medians.size() == 0) begin
            log_mismatch($sformatf("median %0d arrived with none expected", rsp_median));
         end else begin
            want = pending_medians.pop_front();
            medians_checked++;
            if (rsp_median !== want)
               log_mismatch($sformatf("median expected %0d, got %0d", want, rsp_median));
         end
      end
   end

   // Watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no beat for %0d cycles, %0d medians outstanding",
                  IDLE_LIMIT, pending_medians.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_default_window();
      test_zero_window();
      test_unit_window();
      test_equal_samples();
      test_random_windows();
      test_output_stall();
      test_sender_pause();
      test_full_rate();
      pause_sender();
      $display("Run: %0d samples, %0d medians compared, %0d window writes (incl. 0, 1, 32, 63)",
               samples_sent, medians_checked, windows_written);
      $display("Also: a %0d-cycle output hold, a mid-stream sender pause, a back-to-back tail",
               LONG_HOLD);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Mismatches: %0d", mismatch_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
